/* sv/plt_pkg.sv */
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes of the piecewise linear table block.
// ----------------------------------------------------------------------------
package plt_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_SEGMENT  = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_EVAL     = 3'd4,
        OP_SHAPE    = 3'd5,
        OP_FIRST_NZ = 3'd6,
        OP_TABLE    = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SHP_CONST  = 2'd0,
        SHP_NONDEC = 2'd1,
        SHP_NONINC = 2'd2,
        SHP_VARIED = 2'd3
    } shape_t;

    localparam logic REG_CLAMP_MODE = 1'b0;

    typedef enum logic [5:0] {
        C_NOP, C_LOAD, C_KEY_A, C_KEY_B, C_RD_I, C_RD_J1, C_RD_ZERO, C_INC_I,
        C_OVR, C_FAIL, C_J_CNT, C_INS_WR, C_SH_WR, C_ADD_RES, C_SEG_FIX,
        C_CMP_WR, C_CNT_J, C_SET_I0, C_RM_FOUND, C_NOTFOUND, C_CLEAR,
        C_RP_EMPTY, C_RP_LOW, C_RP_HIGH, C_SHS_STEP, C_KEY_EVAL, C_EV_ZERO,
        C_EV_CLAMP, C_EV_NEXT, C_EV_HIT, C_EV_DIV, C_EV_FIN, C_FN_NONE,
        C_FN_HIT, C_T_INIT, C_T_X0, C_T_DIV, C_T_XQ, C_T_EMIT, C_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    i_lt_cnt;
        logic    i_zero;
        logic    j_gt_i;
        logic    key_eq;
        logic    key_lt;
        logic    full;
        logic    second;
        logic    seg_fail;
        logic    seg_drop;
        logic    cnt_zero;
        logic    ev_zero;
        logic    val_nz;
        logic    div_done;
        logic    tbl_empty;
        logic    smp_first;
        logic    smp_last;
    } sts_t;

endpackage

/* sv/plt_muldiv.sv */
// ----------------------------------------------------------------------------
// plt_muldiv
// Computes floor(a * b / c) on unsigned 32-bit operands: shift-add multiply,
// then restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plt_muldiv
    import plt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    output logic        busy,
    output logic        done,
    output logic [31:0] q
);

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;

    logic        busy_reg, busy_next;
    logic        mul_reg, mul_next;
    logic        done_reg, done_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, acc_reg[63]};
    assign diff  = trial - {1'b0, c_reg};
    assign ge    = (trial >= {1'b0, c_reg});

    always_comb
    begin
        busy_next = busy_reg;
        mul_next  = mul_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            mul_next  = 1'b1;
            step_next = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            c_next    = c;
        end
        else if (busy_reg && mul_reg)
        begin
            acc_next  = {acc_reg[62:0], 1'b0} + (b_reg[31] ? {32'd0, a_reg} : 64'd0);
            b_next    = {b_reg[30:0], 1'b0};
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(MUL_STEPS - 1))
            begin
                mul_next  = 1'b0;
                step_next = '0;
                rem_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[31:0] : trial[31:0];
            acc_next  = {acc_reg[62:0], ge};
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q    = acc_reg[31:0];

endmodule

/* sv/plt_dp.sv */
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: point memories, scan pointers, report registers, the mul-div
// unit and the result registers, driven one command per cycle.
// ----------------------------------------------------------------------------
module plt_dp
    import plt_pkg::*;
#(
    parameter int MAX_POINTS        = 64,
    parameter int MAX_TABLE_SAMPLES = 64,
    parameter int IW                = 6,
    parameter int CW                = 7,
    parameter int TW                = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 clamp,
    input  logic [2:0]           opcode,
    input  logic signed [31:0]   position_a,
    input  logic signed [31:0]   value_a,
    input  logic signed [31:0]   position_b,
    input  logic signed [31:0]   value_b,
    input  logic [TW-1:0]        table_count,
    output sts_t                 sts,
    output logic                 result_strobe,
    output logic signed [31:0]   out_value,
    output logic [IW-1:0]        out_index,
    output logic [CW-1:0]        out_count,
    output logic [1:0]           out_shape,
    output logic signed [31:0]   out_low_position,
    output logic signed [31:0]   out_high_position,
    output logic [1:0]           status,
    output logic                 last
);

    logic signed [31:0] pos_mem [MAX_POINTS];
    logic signed [31:0] val_mem [MAX_POINTS];

    opcode_t            op_reg;
    logic signed [31:0] pa_reg, va_reg, pb_reg, vb_reg;
    logic [TW-1:0]      n_reg;
    logic signed [31:0] key_reg, kval_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      i_reg, j_reg;
    logic [CW-1:0]      ia_reg, ib_reg;
    logic               fb_reg, faila_reg, failb_reg, second_reg;
    logic signed [31:0] pos_q, val_q, prev_pos, prev_val;
    logic signed [31:0] low_reg, high_reg, res_reg;
    shape_t             shape_reg;
    status_t            st_reg;
    logic [IW-1:0]      idx_reg;
    logic [TW-1:0]      smp_reg;
    logic               neg_reg;

    logic               strobe_reg;
    logic signed [31:0] o_value_reg, o_low_reg, o_high_reg;
    logic [IW-1:0]      o_index_reg;
    logic [CW-1:0]      o_count_reg;
    shape_t             o_shape_reg;
    status_t            o_status_reg;
    logic               o_last_reg;

    // memory ports
    logic               rd_en;
    logic [CW-1:0]      rd_idx;
    logic               we_pos, we_val;
    logic [CW-1:0]      wr_idx;
    logic signed [31:0] wr_pos, wr_val;

    // mul-div unit
    logic               div_start, div_busy, div_done;
    logic [31:0]        div_a, div_b, div_c, div_q;

    logic [CW-1:0]      ia_adj, seg_lo, seg_hi;
    logic [32:0]        dy, dx;
    logic [32:0]        dy_mag, dx_mag;
    logic [TW:0]        smp_inc;
    logic signed [31:0] q_signed;
    logic signed [31:0] clamped;
    logic               put_slot_b;

    plt_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .c     (div_c),
        .busy  (div_busy),
        .done  (div_done),
        .q     (div_q)
    );

    assign ia_adj  = ia_reg + CW'(fb_reg && (ib_reg <= ia_reg));
    assign seg_lo  = (ia_adj < ib_reg) ? ia_adj : ib_reg;
    assign seg_hi  = (ia_adj < ib_reg) ? ib_reg : ia_adj;
    assign dy      = {val_q[31], val_q} - {prev_val[31], prev_val};
    assign dx      = {pb_reg[31], pb_reg} - {pa_reg[31], pa_reg};
    assign dy_mag  = dy[32] ? -dy : dy;
    assign dx_mag  = dx[32] ? -dx : dx;
    assign smp_inc = {1'b0, smp_reg} + 1'b1;
    assign q_signed = neg_reg ? -div_q : div_q;
    assign clamped = (key_reg < low_reg) ? low_reg :
                     ((key_reg > high_reg) ? high_reg : key_reg);
    assign put_slot_b = second_reg;

    always_comb
    begin
        sts.op        = op_reg;
        sts.i_lt_cnt  = (i_reg < cnt_reg);
        sts.i_zero    = (i_reg == '0);
        sts.j_gt_i    = (j_reg > i_reg);
        sts.key_eq    = (pos_q == key_reg);
        sts.key_lt    = (pos_q < key_reg);
        sts.full      = (cnt_reg >= CW'(MAX_POINTS));
        sts.second    = second_reg;
        sts.seg_fail  = faila_reg | failb_reg;
        sts.seg_drop  = (seg_hi > seg_lo);
        sts.cnt_zero  = (cnt_reg == '0);
        sts.ev_zero   = (cnt_reg == '0) ||
                        (!clamp && ((key_reg < low_reg) || (key_reg > high_reg)));
        sts.val_nz    = (val_q != 32'sd0);
        sts.div_done  = div_done;
        sts.tbl_empty = (n_reg == '0) || (pa_reg == pb_reg);
        sts.smp_first = (smp_reg == '0) || (n_reg == TW'(1));
        sts.smp_last  = (smp_inc == {1'b0, n_reg});
    end

    always_comb
    begin
        rd_en     = 1'b0;
        rd_idx    = i_reg;
        we_pos    = 1'b0;
        we_val    = 1'b0;
        wr_idx    = i_reg;
        wr_pos    = key_reg;
        wr_val    = kval_reg;
        div_start = 1'b0;
        div_a     = dy_mag[31:0];
        div_b     = key_reg - prev_pos;
        div_c     = pos_q - prev_pos;
        case (cmd.op)
            C_RD_I:
            begin
                rd_en = 1'b1;
            end
            C_RD_J1:
            begin
                rd_en  = 1'b1;
                rd_idx = j_reg - 1'b1;
            end
            C_RD_ZERO:
            begin
                rd_en  = 1'b1;
                rd_idx = '0;
            end
            C_RP_LOW:
            begin
                rd_en  = 1'b1;
                rd_idx = cnt_reg - 1'b1;
            end
            C_OVR:
            begin
                we_val = 1'b1;
            end
            C_INS_WR:
            begin
                we_pos = 1'b1;
                we_val = 1'b1;
            end
            C_SH_WR, C_CMP_WR:
            begin
                we_pos = 1'b1;
                we_val = 1'b1;
                wr_idx = j_reg;
                wr_pos = pos_q;
                wr_val = val_q;
            end
            C_EV_DIV:
            begin
                div_start = 1'b1;
            end
            C_T_DIV:
            begin
                div_start = 1'b1;
                div_a     = dx_mag[31:0];
                div_b     = {{(32 - TW){1'b0}}, smp_reg};
                div_c     = {{(32 - TW){1'b0}}, n_reg - 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_pos)
            pos_mem[wr_idx[IW-1:0]] <= wr_pos;
        if (we_val)
            val_mem[wr_idx[IW-1:0]] <= wr_val;
        if (rd_en)
        begin
            pos_q <= pos_mem[rd_idx[IW-1:0]];
            val_q <= val_mem[rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.op == C_EMIT) || (cmd.op == C_T_EMIT);
            case (cmd.op)
                C_INS_WR: cnt_reg <= cnt_reg + 1'b1;
                C_CNT_J:  cnt_reg <= j_reg;
                C_CLEAR:  cnt_reg <= '0;
                default:  cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            C_LOAD:
            begin
                op_reg  <= opcode_t'(opcode);
                pa_reg  <= position_a;
                va_reg  <= value_a;
                pb_reg  <= position_b;
                vb_reg  <= value_b;
                n_reg   <= (table_count > TW'(MAX_TABLE_SAMPLES)) ?
                           TW'(MAX_TABLE_SAMPLES) : table_count;
                st_reg  <= ST_OK;
                idx_reg <= '0;
                res_reg <= 32'sd0;
            end
            C_KEY_A:
            begin
                key_reg    <= pa_reg;
                kval_reg   <= va_reg;
                i_reg      <= '0;
                second_reg <= 1'b0;
            end
            C_KEY_B:
            begin
                key_reg    <= pb_reg;
                kval_reg   <= vb_reg;
                i_reg      <= '0;
                second_reg <= 1'b1;
            end
            C_INC_I:
                i_reg <= i_reg + 1'b1;
            C_OVR, C_INS_WR, C_FAIL:
            begin
                if (put_slot_b)
                begin
                    ib_reg    <= (cmd.op == C_FAIL) ? '0 : i_reg;
                    fb_reg    <= (cmd.op == C_INS_WR);
                    failb_reg <= (cmd.op == C_FAIL);
                end
                else
                begin
                    ia_reg    <= (cmd.op == C_FAIL) ? '0 : i_reg;
                    faila_reg <= (cmd.op == C_FAIL);
                end
            end
            C_J_CNT:
                j_reg <= cnt_reg;
            C_SH_WR:
                j_reg <= j_reg - 1'b1;
            C_ADD_RES:
            begin
                idx_reg <= faila_reg ? '0 : ia_reg[IW-1:0];
                st_reg  <= faila_reg ? ST_FULL : ST_OK;
            end
            C_SEG_FIX:
            begin
                if (faila_reg || failb_reg)
                begin
                    idx_reg <= '0;
                    st_reg  <= ST_FULL;
                end
                else
                begin
                    idx_reg <= seg_lo[IW-1:0];
                    st_reg  <= ST_OK;
                    i_reg   <= seg_hi;
                    j_reg   <= seg_lo + 1'b1;
                end
            end
            C_CMP_WR:
            begin
                i_reg <= i_reg + 1'b1;
                j_reg <= j_reg + 1'b1;
            end
            C_SET_I0:
                i_reg <= '0;
            C_RM_FOUND:
            begin
                j_reg <= i_reg;
                i_reg <= i_reg + 1'b1;
            end
            C_NOTFOUND:
                st_reg <= ST_NOT_FOUND;
            C_RP_EMPTY:
            begin
                low_reg   <= 32'sd0;
                high_reg  <= 32'sd0;
                shape_reg <= SHP_CONST;
            end
            C_RP_LOW:
            begin
                low_reg   <= pos_q;
                prev_val  <= val_q;
                shape_reg <= SHP_CONST;
                i_reg     <= CW'(1);
            end
            C_RP_HIGH:
                high_reg <= pos_q;
            C_SHS_STEP:
            begin
                if (val_q > prev_val)
                    shape_reg <= (shape_reg == SHP_NONINC || shape_reg == SHP_VARIED) ?
                                 SHP_VARIED : SHP_NONDEC;
                else if (val_q < prev_val)
                    shape_reg <= (shape_reg == SHP_NONDEC || shape_reg == SHP_VARIED) ?
                                 SHP_VARIED : SHP_NONINC;
                prev_val <= val_q;
                i_reg    <= i_reg + 1'b1;
            end
            C_KEY_EVAL:
                key_reg <= pa_reg;
            C_EV_ZERO:
                res_reg <= 32'sd0;
            C_EV_CLAMP:
            begin
                key_reg <= clamped;
                i_reg   <= '0;
            end
            C_EV_NEXT:
            begin
                prev_pos <= pos_q;
                prev_val <= val_q;
                i_reg    <= i_reg + 1'b1;
            end
            C_EV_HIT:
                res_reg <= val_q;
            C_EV_DIV:
                neg_reg <= dy[32];
            C_EV_FIN:
                res_reg <= prev_val + q_signed;
            C_FN_NONE:
                res_reg <= low_reg;
            C_FN_HIT:
                res_reg <= (i_reg == '0) ? pos_q : prev_pos;
            C_T_INIT:
                smp_reg <= '0;
            C_T_X0:
                key_reg <= pa_reg;
            C_T_DIV:
                neg_reg <= dx[32];
            C_T_XQ:
                key_reg <= pa_reg + q_signed;
            C_T_EMIT:
                smp_reg <= smp_reg + 1'b1;
            default:
            begin
            end
        endcase

        if (cmd.op == C_EMIT || cmd.op == C_T_EMIT)
        begin
            o_value_reg  <= res_reg;
            o_index_reg  <= idx_reg;
            o_count_reg  <= cnt_reg;
            o_shape_reg  <= shape_reg;
            o_low_reg    <= low_reg;
            o_high_reg   <= high_reg;
            o_status_reg <= st_reg;
            o_last_reg   <= (cmd.op == C_EMIT) ? 1'b1 : sts.smp_last;
        end
    end

    assign result_strobe     = strobe_reg;
    assign out_value         = o_value_reg;
    assign out_index         = o_index_reg;
    assign out_count         = o_count_reg;
    assign out_shape         = o_shape_reg;
    assign out_low_position  = o_low_reg;
    assign out_high_position = o_high_reg;
    assign status            = o_status_reg;
    assign last              = o_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count above table size");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("mul-div started while busy");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (we_pos || we_val) |-> (wr_idx <= cnt_reg))
        else $error("memory write beyond stored points");

endmodule

/* sv/plt_ctrl.sv */
// ----------------------------------------------------------------------------
// plt_ctrl
// Controller: sequences each operation as scans, shifts and divisions of the
// datapath, one command per cycle.
// ----------------------------------------------------------------------------
module plt_ctrl
    import plt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [29:0] {
        S_IDLE    = 30'd1 << 0,
        S_DISP    = 30'd1 << 1,
        S_P_RD    = 30'd1 << 2,
        S_P_CK    = 30'd1 << 3,
        S_P_INS   = 30'd1 << 4,
        S_SH_RD   = 30'd1 << 5,
        S_SH_WR   = 30'd1 << 6,
        S_P_END   = 30'd1 << 7,
        S_SEG_FIX = 30'd1 << 8,
        S_CMP_RD  = 30'd1 << 9,
        S_CMP_WR  = 30'd1 << 10,
        S_RM_RD   = 30'd1 << 11,
        S_RM_CK   = 30'd1 << 12,
        S_RP0     = 30'd1 << 13,
        S_RP1     = 30'd1 << 14,
        S_RP2     = 30'd1 << 15,
        S_SHS_RD  = 30'd1 << 16,
        S_SHS_CK  = 30'd1 << 17,
        S_POST    = 30'd1 << 18,
        S_EV0     = 30'd1 << 19,
        S_EV_RD   = 30'd1 << 20,
        S_EV_CK   = 30'd1 << 21,
        S_EV_WAIT = 30'd1 << 22,
        S_EV_DONE = 30'd1 << 23,
        S_FN_RD   = 30'd1 << 24,
        S_FN_CK   = 30'd1 << 25,
        S_T_POS   = 30'd1 << 26,
        S_T_WAIT  = 30'd1 << 27,
        S_T_EMIT  = 30'd1 << 28,
        S_EMIT    = 30'd1 << 29
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = C_NOP;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op     = C_LOAD;
                    state_next = S_DISP;
                end
            S_DISP:
                case (sts.op)
                    OP_ADD, OP_SEGMENT:
                    begin
                        cmd.op     = C_KEY_A;
                        state_next = S_P_RD;
                    end
                    OP_REMOVE:
                    begin
                        cmd.op     = C_KEY_A;
                        state_next = S_RM_RD;
                    end
                    OP_CLEAR:
                    begin
                        cmd.op     = C_CLEAR;
                        state_next = S_RP0;
                    end
                    default:
                        state_next = S_RP0;
                endcase
            // insert or overwrite one point
            S_P_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_P_CK;
                end
                else
                    state_next = S_P_INS;
            S_P_CK:
                if (sts.key_eq)
                begin
                    cmd.op     = C_OVR;
                    state_next = S_P_END;
                end
                else if (sts.key_lt)
                begin
                    cmd.op     = C_INC_I;
                    state_next = S_P_RD;
                end
                else
                    state_next = S_P_INS;
            S_P_INS:
                if (sts.full)
                begin
                    cmd.op     = C_FAIL;
                    state_next = S_P_END;
                end
                else
                begin
                    cmd.op     = C_J_CNT;
                    state_next = S_SH_RD;
                end
            S_SH_RD:
                if (sts.j_gt_i)
                begin
                    cmd.op     = C_RD_J1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.op     = C_INS_WR;
                    state_next = S_P_END;
                end
            S_SH_WR:
            begin
                cmd.op     = C_SH_WR;
                state_next = S_SH_RD;
            end
            S_P_END:
                if (sts.op == OP_ADD)
                begin
                    cmd.op     = C_ADD_RES;
                    state_next = S_RP0;
                end
                else if (!sts.second)
                begin
                    cmd.op     = C_KEY_B;
                    state_next = S_P_RD;
                end
                else
                    state_next = S_SEG_FIX;
            S_SEG_FIX:
            begin
                cmd.op     = C_SEG_FIX;
                state_next = (!sts.seg_fail && sts.seg_drop) ? S_CMP_RD : S_RP0;
            end
            // move entries down from source i to destination j
            S_CMP_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_CMP_WR;
                end
                else
                begin
                    cmd.op     = C_CNT_J;
                    state_next = S_RP0;
                end
            S_CMP_WR:
            begin
                cmd.op     = C_CMP_WR;
                state_next = S_CMP_RD;
            end
            S_RM_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_RM_CK;
                end
                else
                begin
                    cmd.op     = C_NOTFOUND;
                    state_next = S_RP0;
                end
            S_RM_CK:
                if (sts.key_eq)
                begin
                    cmd.op     = C_RM_FOUND;
                    state_next = S_CMP_RD;
                end
                else
                begin
                    cmd.op     = C_INC_I;
                    state_next = S_RM_RD;
                end
            // range and shape of the stored points
            S_RP0:
                if (sts.cnt_zero)
                begin
                    cmd.op     = C_RP_EMPTY;
                    state_next = S_POST;
                end
                else
                begin
                    cmd.op     = C_RD_ZERO;
                    state_next = S_RP1;
                end
            S_RP1:
            begin
                cmd.op     = C_RP_LOW;
                state_next = S_RP2;
            end
            S_RP2:
            begin
                cmd.op     = C_RP_HIGH;
                state_next = S_SHS_RD;
            end
            S_SHS_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_SHS_CK;
                end
                else
                    state_next = S_POST;
            S_SHS_CK:
            begin
                cmd.op     = C_SHS_STEP;
                state_next = S_SHS_RD;
            end
            S_POST:
                case (sts.op)
                    OP_EVAL:
                    begin
                        cmd.op     = C_KEY_EVAL;
                        state_next = S_EV0;
                    end
                    OP_FIRST_NZ:
                        if (sts.cnt_zero)
                            state_next = S_EMIT;
                        else
                        begin
                            cmd.op     = C_SET_I0;
                            state_next = S_FN_RD;
                        end
                    OP_TABLE:
                        if (sts.tbl_empty)
                            state_next = S_IDLE;
                        else
                        begin
                            cmd.op     = C_T_INIT;
                            state_next = S_T_POS;
                        end
                    default:
                        state_next = S_EMIT;
                endcase
            // evaluate at the key position
            S_EV0:
                if (sts.ev_zero)
                begin
                    cmd.op     = C_EV_ZERO;
                    state_next = S_EV_DONE;
                end
                else
                begin
                    cmd.op     = C_EV_CLAMP;
                    state_next = S_EV_RD;
                end
            S_EV_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_EV_CK;
                end
                else
                begin
                    cmd.op     = C_EV_ZERO;
                    state_next = S_EV_DONE;
                end
            S_EV_CK:
                if (sts.key_lt)
                begin
                    cmd.op     = C_EV_NEXT;
                    state_next = S_EV_RD;
                end
                else if (sts.key_eq || sts.i_zero)
                begin
                    cmd.op     = C_EV_HIT;
                    state_next = S_EV_DONE;
                end
                else
                begin
                    cmd.op     = C_EV_DIV;
                    state_next = S_EV_WAIT;
                end
            S_EV_WAIT:
                if (sts.div_done)
                begin
                    cmd.op     = C_EV_FIN;
                    state_next = S_EV_DONE;
                end
            S_EV_DONE:
                state_next = (sts.op == OP_TABLE) ? S_T_EMIT : S_EMIT;
            S_FN_RD:
                if (sts.i_lt_cnt)
                begin
                    cmd.op     = C_RD_I;
                    state_next = S_FN_CK;
                end
                else
                begin
                    cmd.op     = C_FN_NONE;
                    state_next = S_EMIT;
                end
            S_FN_CK:
                if (sts.val_nz)
                begin
                    cmd.op     = C_FN_HIT;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = C_EV_NEXT;
                    state_next = S_FN_RD;
                end
            // sample positions of the table
            S_T_POS:
                if (sts.smp_first)
                begin
                    cmd.op     = C_T_X0;
                    state_next = S_EV0;
                end
                else
                begin
                    cmd.op     = C_T_DIV;
                    state_next = S_T_WAIT;
                end
            S_T_WAIT:
                if (sts.div_done)
                begin
                    cmd.op     = C_T_XQ;
                    state_next = S_EV0;
                end
            S_T_EMIT:
            begin
                cmd.op     = C_T_EMIT;
                state_next = sts.smp_last ? S_IDLE : S_T_POS;
            end
            S_EMIT:
            begin
                cmd.op     = C_EMIT;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* sv/piecewise_linear_table.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_table
// Sorted table of Q16.16 breakpoints with insert, remove, segment, clear,
// interpolation, shape, first nonzero and sampled table operations.
//
// channel   direction  handshake                       payload
// command   in         start && !busy                  opcode, positions, values,
//                                                      table_count
// result    out        result_strobe, one cycle each   out_* fields, status, last
// config    in         apb write, psel&penable&pwrite  clamp_mode at addresses 0-3 (paddr[2] low)
//
// work: a point search or shift walks over the N stored points, plus a
// range and shape pass per item; an interpolation adds a pass through
// the shared mul-div unit (32 multiply steps, 64 divide steps)
// table: n samples; each but the first takes a mul-div pass for its position, then a search and interpolation
// reset: the point count clears; point memories are not cleared
// results cannot be stalled; the next item is taken once busy falls
// ----------------------------------------------------------------------------
module piecewise_linear_table
    import plt_pkg::*;
#(
    parameter int MAX_POINTS        = 64,
    parameter int MAX_TABLE_SAMPLES = 64
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [2:0]                              opcode,
    input  logic signed [31:0]                      position_a,
    input  logic signed [31:0]                      value_a,
    input  logic signed [31:0]                      position_b,
    input  logic signed [31:0]                      value_b,
    input  logic [$clog2(MAX_TABLE_SAMPLES+1)-1:0]  table_count,
    output logic                                    result_strobe,
    output logic signed [31:0]                      out_value,
    output logic [$clog2(MAX_POINTS)-1:0]           out_index,
    output logic [$clog2(MAX_POINTS+1)-1:0]         out_count,
    output logic [1:0]                              out_shape,
    output logic signed [31:0]                      out_low_position,
    output logic signed [31:0]                      out_high_position,
    output logic [1:0]                              status,
    output logic                                    last,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = $clog2(MAX_TABLE_SAMPLES + 1);

    logic clamp_reg, clamp_next;
    cmd_t cmd;
    sts_t sts;
    logic reg_hit;

    assign reg_hit    = (paddr[2] == REG_CLAMP_MODE);
    assign pready     = 1'b1;
    assign prdata     = reg_hit ? {31'd0, clamp_reg} : 32'd0;
    assign clamp_next = (psel && penable && pwrite && reg_hit) ? pwdata[0] : clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_reg <= 1'b1;
        else
            clamp_reg <= clamp_next;
    end

    plt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    plt_dp #(
        .MAX_POINTS        (MAX_POINTS),
        .MAX_TABLE_SAMPLES (MAX_TABLE_SAMPLES),
        .IW                (IW),
        .CW                (CW),
        .TW                (TW)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .clamp             (clamp_reg),
        .opcode            (opcode),
        .position_a        (position_a),
        .value_a           (value_a),
        .position_b        (position_b),
        .value_b           (value_b),
        .table_count       (table_count),
        .sts               (sts),
        .result_strobe     (result_strobe),
        .out_value         (out_value),
        .out_index         (out_index),
        .out_count         (out_count),
        .out_shape         (out_shape),
        .out_low_position  (out_low_position),
        .out_high_position (out_high_position),
        .status            (status),
        .last              (last)
    );

endmodule
